>>> rtl/core/aqf_pkg.sv
package aqf_pkg;

  // field widths
  localparam int unsigned CfgW   = 31;
  localparam int unsigned CfgAW  = 3;
  localparam int unsigned InDW   = 216;
  localparam int unsigned OutDW  = 128;
  localparam int unsigned PcW    = 7;
  localparam int unsigned DivSteps  = 62;
  localparam int unsigned SqrtSteps = 32;

  // quaternion one in Q2.30
  localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

  // configuration register indexes
  localparam logic [CfgAW-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CfgAW-1:0] REG_INTEGRAL_GAIN  = 3'd1;
  localparam logic [CfgAW-1:0] REG_INTEGRAL_LIMIT = 3'd2;
  localparam logic [CfgAW-1:0] REG_GATE_LOW       = 3'd3;
  localparam logic [CfgAW-1:0] REG_GATE_HIGH      = 3'd4;

  // result status codes
  typedef enum logic [1:0] {
    STAT_CORR  = 2'd0,
    STAT_GYRO  = 2'd1,
    STAT_SKIP  = 2'd2,
    STAT_RESET = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ACC,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    K_MUL,
    K_SQRT,
    K_DIV,
    K_GATE,
    K_NZ,
    K_END
  } kind_t;

  typedef enum logic [5:0] {
    S_A0, S_A1, S_A2,
    S_G0, S_G1, S_G2,
    S_Q0, S_Q1, S_Q2, S_Q3,
    S_AN0, S_AN1, S_AN2,
    S_V0, S_V1, S_V2,
    S_E0, S_E1, S_E2,
    S_I0, S_I1, S_I2,
    S_H0, S_H1, S_H2,
    S_QN0, S_QN1, S_QN2, S_QN3,
    S_ONE, S_PG, S_IG, S_DT
  } src_t;

  typedef enum logic [4:0] {
    D_NONE,
    D_V0, D_V1, D_V2,
    D_E0, D_E1, D_E2,
    D_I0, D_I1, D_I2,
    D_G0, D_G1, D_G2,
    D_H0, D_H1, D_H2,
    D_QN0, D_QN1, D_QN2, D_QN3,
    D_AN0, D_AN1, D_AN2,
    D_Q0, D_Q1, D_Q2, D_Q3
  } dst_t;

  typedef enum logic [1:0] {
    FN_SAT,
    FN_SAT2,
    FN_CLAMP,
    FN_SYM
  } fn_t;

  typedef enum logic [2:0] {
    SH_0,
    SH_11,
    SH_14,
    SH_24,
    SH_30,
    SH_38
  } sh_t;

  typedef struct packed {
    kind_t kind;
    src_t  a;
    src_t  b;
    sh_t   sh;
    logic  sub;
    logic  first;
    dst_t  dst;
    fn_t   fn;
  } uop_t;

  // first step of the rate integration
  localparam logic [PcW-1:0] PcHalf = 7'd37;

  function automatic uop_t um(kind_t k, src_t a, src_t b, sh_t s, logic sub,
                              logic first, dst_t d, fn_t f);
    uop_t u;
    u.kind  = k;
    u.a     = a;
    u.b     = b;
    u.sh    = s;
    u.sub   = sub;
    u.first = first;
    u.dst   = d;
    u.fn    = f;
    return u;
  endfunction

  // microprogram of one sample update
  function automatic uop_t ucode(logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      // accel sum of squares, magnitude, normalised accel
      7'd0:  u = um(K_MUL, S_A0, S_A0, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd1:  u = um(K_MUL, S_A1, S_A1, SH_0, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd2:  u = um(K_MUL, S_A2, S_A2, SH_0, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd3:  u = um(K_SQRT, S_ONE, S_ONE, SH_0, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd4:  u = um(K_DIV, S_A0, S_ONE, SH_0, 1'b0, 1'b0, D_AN0, FN_SAT);
      7'd5:  u = um(K_DIV, S_A1, S_ONE, SH_0, 1'b0, 1'b0, D_AN1, FN_SAT);
      7'd6:  u = um(K_DIV, S_A2, S_ONE, SH_0, 1'b0, 1'b0, D_AN2, FN_SAT);
      // predicted gravity
      7'd7:  u = um(K_MUL, S_Q1, S_Q3, SH_30, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd8:  u = um(K_MUL, S_Q0, S_Q2, SH_30, 1'b1, 1'b0, D_V0, FN_SAT2);
      7'd9:  u = um(K_MUL, S_Q0, S_Q1, SH_30, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd10: u = um(K_MUL, S_Q2, S_Q3, SH_30, 1'b0, 1'b0, D_V1, FN_SAT2);
      7'd11: u = um(K_MUL, S_Q0, S_Q0, SH_30, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd12: u = um(K_MUL, S_Q1, S_Q1, SH_30, 1'b1, 1'b0, D_NONE, FN_SAT);
      7'd13: u = um(K_MUL, S_Q2, S_Q2, SH_30, 1'b1, 1'b0, D_NONE, FN_SAT);
      7'd14: u = um(K_MUL, S_Q3, S_Q3, SH_30, 1'b0, 1'b0, D_V2, FN_SAT);
      7'd15: u = um(K_GATE, S_ONE, S_ONE, SH_0, 1'b0, 1'b0, D_NONE, FN_SAT);
      // cross product error
      7'd16: u = um(K_MUL, S_AN1, S_V2, SH_30, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd17: u = um(K_MUL, S_AN2, S_V1, SH_30, 1'b1, 1'b0, D_E0, FN_SAT);
      7'd18: u = um(K_MUL, S_AN2, S_V0, SH_30, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd19: u = um(K_MUL, S_AN0, S_V2, SH_30, 1'b1, 1'b0, D_E1, FN_SAT);
      7'd20: u = um(K_MUL, S_AN0, S_V1, SH_30, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd21: u = um(K_MUL, S_AN1, S_V0, SH_30, 1'b1, 1'b0, D_E2, FN_SAT);
      // integral and rate correction, x
      7'd22: u = um(K_MUL, S_I0, S_ONE, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd23: u = um(K_MUL, S_E0, S_IG, SH_24, 1'b0, 1'b0, D_I0, FN_CLAMP);
      7'd24: u = um(K_MUL, S_G0, S_ONE, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd25: u = um(K_MUL, S_PG, S_E0, SH_38, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd26: u = um(K_MUL, S_I0, S_ONE, SH_14, 1'b0, 1'b0, D_G0, FN_SAT);
      // y
      7'd27: u = um(K_MUL, S_I1, S_ONE, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd28: u = um(K_MUL, S_E1, S_IG, SH_24, 1'b0, 1'b0, D_I1, FN_CLAMP);
      7'd29: u = um(K_MUL, S_G1, S_ONE, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd30: u = um(K_MUL, S_PG, S_E1, SH_38, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd31: u = um(K_MUL, S_I1, S_ONE, SH_14, 1'b0, 1'b0, D_G1, FN_SAT);
      // z
      7'd32: u = um(K_MUL, S_I2, S_ONE, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd33: u = um(K_MUL, S_E2, S_IG, SH_24, 1'b0, 1'b0, D_I2, FN_CLAMP);
      7'd34: u = um(K_MUL, S_G2, S_ONE, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd35: u = um(K_MUL, S_PG, S_E2, SH_38, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd36: u = um(K_MUL, S_I2, S_ONE, SH_14, 1'b0, 1'b0, D_G2, FN_SAT);
      // half-angle increments
      7'd37: u = um(K_MUL, S_G0, S_DT, SH_11, 1'b0, 1'b1, D_H0, FN_SAT);
      7'd38: u = um(K_MUL, S_G1, S_DT, SH_11, 1'b0, 1'b1, D_H1, FN_SAT);
      7'd39: u = um(K_MUL, S_G2, S_DT, SH_11, 1'b0, 1'b1, D_H2, FN_SAT);
      // quaternion integration from the old components
      7'd40: u = um(K_MUL, S_Q0, S_ONE, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd41: u = um(K_MUL, S_Q1, S_H0, SH_30, 1'b1, 1'b0, D_NONE, FN_SAT);
      7'd42: u = um(K_MUL, S_Q2, S_H1, SH_30, 1'b1, 1'b0, D_NONE, FN_SAT);
      7'd43: u = um(K_MUL, S_Q3, S_H2, SH_30, 1'b1, 1'b0, D_QN0, FN_SYM);
      7'd44: u = um(K_MUL, S_Q1, S_ONE, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd45: u = um(K_MUL, S_Q0, S_H0, SH_30, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd46: u = um(K_MUL, S_Q2, S_H2, SH_30, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd47: u = um(K_MUL, S_Q3, S_H1, SH_30, 1'b1, 1'b0, D_QN1, FN_SYM);
      7'd48: u = um(K_MUL, S_Q2, S_ONE, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd49: u = um(K_MUL, S_Q0, S_H1, SH_30, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd50: u = um(K_MUL, S_Q1, S_H2, SH_30, 1'b1, 1'b0, D_NONE, FN_SAT);
      7'd51: u = um(K_MUL, S_Q3, S_H0, SH_30, 1'b0, 1'b0, D_QN2, FN_SYM);
      7'd52: u = um(K_MUL, S_Q3, S_ONE, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd53: u = um(K_MUL, S_Q0, S_H2, SH_30, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd54: u = um(K_MUL, S_Q1, S_H1, SH_30, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd55: u = um(K_MUL, S_Q2, S_H0, SH_30, 1'b1, 1'b0, D_QN3, FN_SYM);
      // renormalisation
      7'd56: u = um(K_MUL, S_QN0, S_QN0, SH_0, 1'b0, 1'b1, D_NONE, FN_SAT);
      7'd57: u = um(K_MUL, S_QN1, S_QN1, SH_0, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd58: u = um(K_MUL, S_QN2, S_QN2, SH_0, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd59: u = um(K_MUL, S_QN3, S_QN3, SH_0, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd60: u = um(K_SQRT, S_ONE, S_ONE, SH_0, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd61: u = um(K_NZ, S_ONE, S_ONE, SH_0, 1'b0, 1'b0, D_NONE, FN_SAT);
      7'd62: u = um(K_DIV, S_QN0, S_ONE, SH_0, 1'b0, 1'b0, D_Q0, FN_SAT);
      7'd63: u = um(K_DIV, S_QN1, S_ONE, SH_0, 1'b0, 1'b0, D_Q1, FN_SAT);
      7'd64: u = um(K_DIV, S_QN2, S_ONE, SH_0, 1'b0, 1'b0, D_Q2, FN_SAT);
      7'd65: u = um(K_DIV, S_QN3, S_ONE, SH_0, 1'b0, 1'b0, D_Q3, FN_SAT);
      default: u = um(K_END, S_ONE, S_ONE, SH_0, 1'b0, 1'b0, D_NONE, FN_SAT);
    endcase
    return u;
  endfunction

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(logic signed [66:0] x);
    logic signed [31:0] r;
    if (x > 67'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -67'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/attitude_quaternion_fusion_top.sv
// Attitude estimator for a gyro plus accelerometer: each input transfer is one sample or a
// reset command, and each gives exactly one result transfer holding the attitude quaternion
// (Q2.30) and a status. A sample's work goes on seven restoring divisions (three for the
// accelerometer, four for renormalisation, skipped if the new norm is zero), two square roots
// and up to 55 steps of the one shared 32x32 multiplier and accumulator; a reset command or
// an all-zero accelerometer skips all of them. in_tready is high only while the block is
// idle; a finished result waits in the output register and the next sample may be taken
// meanwhile. Gains and gate thresholds are to be written through the cfg port only while
// the block is idle; the block itself does not enforce this.
module attitude_quaternion_fusion_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, time_step
  input  logic [aqf_pkg::InDW-1:0]      in_tdata,
  // mode
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [aqf_pkg::OutDW-1:0]     out_tdata,
  // status
  output logic [1:0]                    out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [aqf_pkg::CfgAW-1:0]     cfg_addr,
  input  logic [aqf_pkg::CfgW-1:0]      cfg_wdata
);
  import aqf_pkg::*;

  // configuration
  logic [CfgW-1:0] prop_gain_r, integral_gain_r, integral_limit_r, gate_low_r, gate_high_r;

  // control
  state_t            state_r, state_nxt;
  logic [PcW-1:0]    pc_r;
  status_t           status_r;

  // working registers
  logic signed [31:0] a_r  [3];
  logic signed [31:0] g_r  [3];
  logic signed [31:0] an_r [3];
  logic signed [31:0] v_r  [3];
  logic signed [31:0] e_r  [3];
  logic signed [31:0] h_r  [3];
  logic signed [31:0] integ_r [3];
  logic signed [31:0] qn_r [4];
  logic signed [31:0] att_r [4];
  logic [23:0]        dt_r;
  logic [31:0]        norm_r;

  // shared multiplier and accumulator
  logic signed [64:0] prod_r;
  logic signed [65:0] acc_r, acc_nxt;

  // square root unit
  logic [63:0] sqx_r, sqr_r, sqb_r;
  logic [4:0]  sqcnt_r;

  // divider unit
  logic [DivSteps-1:0] dnum_r, dquo_r;
  logic [31:0]         drem_r;
  logic                dneg_r;
  logic [5:0]          dcnt_r;

  // output register
  logic [OutDW-1:0] out_data_r;
  logic [1:0]       out_user_r;
  logic             out_valid_r;

  uop_t uop;
  assign uop = ucode(pc_r);

  logic in_xfer, out_free, acc_zero, gate_ok;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign acc_zero = (in_tdata[191:96] == '0);
  assign gate_ok  = (norm_r > {1'b0, gate_low_r}) && (norm_r < {1'b0, gate_high_r});

  // operand select
  function automatic logic signed [32:0] opnd(src_t s);
    logic signed [32:0] r;
    case (s)
      S_A0:  r = 33'(a_r[0]);
      S_A1:  r = 33'(a_r[1]);
      S_A2:  r = 33'(a_r[2]);
      S_G0:  r = 33'(g_r[0]);
      S_G1:  r = 33'(g_r[1]);
      S_G2:  r = 33'(g_r[2]);
      S_Q0:  r = 33'(att_r[0]);
      S_Q1:  r = 33'(att_r[1]);
      S_Q2:  r = 33'(att_r[2]);
      S_Q3:  r = 33'(att_r[3]);
      S_AN0: r = 33'(an_r[0]);
      S_AN1: r = 33'(an_r[1]);
      S_AN2: r = 33'(an_r[2]);
      S_V0:  r = 33'(v_r[0]);
      S_V1:  r = 33'(v_r[1]);
      S_V2:  r = 33'(v_r[2]);
      S_E0:  r = 33'(e_r[0]);
      S_E1:  r = 33'(e_r[1]);
      S_E2:  r = 33'(e_r[2]);
      S_I0:  r = 33'(integ_r[0]);
      S_I1:  r = 33'(integ_r[1]);
      S_I2:  r = 33'(integ_r[2]);
      S_H0:  r = 33'(h_r[0]);
      S_H1:  r = 33'(h_r[1]);
      S_H2:  r = 33'(h_r[2]);
      S_QN0: r = 33'(qn_r[0]);
      S_QN1: r = 33'(qn_r[1]);
      S_QN2: r = 33'(qn_r[2]);
      S_QN3: r = 33'(qn_r[3]);
      S_PG:  r = $signed({2'b00, prop_gain_r});
      S_IG:  r = $signed({2'b00, integral_gain_r});
      S_DT:  r = $signed({9'd0, dt_r});
      default: r = 33'sd1;
    endcase
    return r;
  endfunction

  // magnitude product with rounding shift
  logic signed [32:0] op_a, op_b, abs_a, abs_b;
  logic [63:0]        mprod, mrnd, msum, mshift;
  logic signed [64:0] mul_res;

  always_comb begin
    op_a  = opnd(uop.a);
    op_b  = opnd(uop.b);
    abs_a = op_a[32] ? -op_a : op_a;
    abs_b = op_b[32] ? -op_b : op_b;
    mprod = {32'd0, abs_a[31:0]} * {32'd0, abs_b[31:0]};
    case (uop.sh)
      SH_11:   mrnd = 64'd1 << 10;
      SH_14:   mrnd = 64'd1 << 13;
      SH_24:   mrnd = 64'd1 << 23;
      SH_30:   mrnd = 64'd1 << 29;
      SH_38:   mrnd = 64'd1 << 37;
      default: mrnd = 64'd0;
    endcase
    msum = mprod + mrnd;
    case (uop.sh)
      SH_11:   mshift = msum >> 11;
      SH_14:   mshift = msum >> 14;
      SH_24:   mshift = msum >> 24;
      SH_30:   mshift = msum >> 30;
      SH_38:   mshift = msum >> 38;
      default: mshift = msum;
    endcase
    mul_res = (op_a[32] ^ op_b[32]) ? -$signed({1'b0, mshift}) : $signed({1'b0, mshift});
  end

  // accumulate and write-back value
  logic signed [65:0] term, lim;
  logic signed [31:0] acc_wb;

  always_comb begin
    term    = uop.sub ? -66'(prod_r) : 66'(prod_r);
    acc_nxt = uop.first ? term : acc_r + term;
    lim     = $signed({35'd0, integral_limit_r});
    case (uop.fn)
      FN_SAT2: acc_wb = sat32(67'(acc_nxt) <<< 1);
      FN_CLAMP: begin
        if (acc_nxt > lim) begin
          acc_wb = lim[31:0];
        end else if (acc_nxt < -lim) begin
          acc_wb = -lim[31:0];
        end else begin
          acc_wb = acc_nxt[31:0];
        end
      end
      FN_SYM: begin
        if (acc_nxt > 66'sh7FFF_FFFF) begin
          acc_wb = 32'sh7FFF_FFFF;
        end else if (acc_nxt < -66'sh7FFF_FFFF) begin
          acc_wb = -32'sh7FFF_FFFF;
        end else begin
          acc_wb = acc_nxt[31:0];
        end
      end
      default: acc_wb = sat32(67'(acc_nxt));
    endcase
  end

  // square root step
  logic [63:0] sq_try;
  logic        sq_ge;
  assign sq_try = sqr_r + sqb_r;
  assign sq_ge  = (sqx_r >= sq_try);

  // divider step and final saturation
  logic [32:0]         d_try;
  logic                d_ge;
  logic [DivSteps-1:0] d_quo;
  logic signed [31:0]  div_res;
  logic [31:0]         dmag;
  logic signed [32:0]  div_src;

  always_comb begin
    d_try = {drem_r, dnum_r[DivSteps-1]};
    d_ge  = (d_try >= {1'b0, norm_r});
    d_quo = {dquo_r[DivSteps-2:0], d_ge};
    if (dneg_r) begin
      div_res = (d_quo > DivSteps'(64'h8000_0000)) ? -32'sh8000_0000 : -d_quo[31:0];
    end else begin
      div_res = (d_quo > DivSteps'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : d_quo[31:0];
    end
    div_src = op_a[32] ? -op_a : op_a;
    dmag    = div_src[31:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_tuser || acc_zero) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: begin
        case (uop.kind)
          K_MUL:  state_nxt = ST_ACC;
          K_SQRT: state_nxt = ST_SQRT;
          K_DIV:  state_nxt = ST_DIV;
          K_NZ:   state_nxt = (norm_r == '0) ? ST_DONE : ST_FETCH;
          K_END:  state_nxt = ST_DONE;
          default: state_nxt = ST_FETCH;
        endcase
      end
      ST_ACC:  state_nxt = ST_FETCH;
      ST_SQRT: state_nxt = (sqcnt_r == 5'(SqrtSteps - 1)) ? ST_FETCH : ST_SQRT;
      ST_DIV:  state_nxt = (dcnt_r == 6'(DivSteps - 1)) ? ST_FETCH : ST_DIV;
      ST_DONE: state_nxt = out_free ? ST_IDLE : ST_DONE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  logic               wb_en;
  dst_t               wb_dst;
  logic signed [31:0] wb_val;

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    wb_en     = 1'b0;
    wb_dst    = uop.dst;
    wb_val    = acc_wb;
    if (state_r == ST_ACC && uop.dst != D_NONE) begin
      wb_en = 1'b1;
    end else if (state_r == ST_DIV && dcnt_r == 6'(DivSteps - 1)) begin
      wb_en  = 1'b1;
      wb_val = div_res;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r      <= 31'd33554432;
      integral_gain_r  <= 31'd83886;
      integral_limit_r <= 31'd107374182;
      gate_low_r       <= 31'd52429;
      gate_high_r      <= 31'd78643;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PROP_GAIN:      prop_gain_r      <= cfg_wdata;
        REG_INTEGRAL_GAIN:  integral_gain_r  <= cfg_wdata;
        REG_INTEGRAL_LIMIT: integral_limit_r <= cfg_wdata;
        REG_GATE_LOW:       gate_low_r       <= cfg_wdata;
        REG_GATE_HIGH:      gate_high_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pc_r     <= '0;
      status_r <= STAT_RESET;
      att_r[0] <= OneQ30;
      att_r[1] <= '0;
      att_r[2] <= '0;
      att_r[3] <= '0;
      for (int k = 0; k < 3; k++) begin
        integ_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            pc_r <= '0;
            if (in_tuser) begin
              status_r <= STAT_RESET;
              att_r[0] <= OneQ30;
              att_r[1] <= '0;
              att_r[2] <= '0;
              att_r[3] <= '0;
              for (int k = 0; k < 3; k++) begin
                integ_r[k] <= '0;
              end
            end else if (acc_zero) begin
              status_r <= STAT_SKIP;
            end
          end
        end
        ST_FETCH: begin
          case (uop.kind)
            K_GATE: begin
              if (gate_ok) begin
                status_r <= STAT_CORR;
                pc_r     <= pc_r + 7'd1;
              end else begin
                status_r <= STAT_GYRO;
                pc_r     <= PcHalf;
              end
            end
            K_NZ: begin
              pc_r <= pc_r + 7'd1;
              if (norm_r == '0) begin
                att_r[0] <= OneQ30;
                att_r[1] <= '0;
                att_r[2] <= '0;
                att_r[3] <= '0;
              end
            end
            default: ;
          endcase
        end
        ST_ACC:  pc_r <= pc_r + 7'd1;
        ST_SQRT: begin
          if (sqcnt_r == 5'(SqrtSteps - 1)) begin
            pc_r <= pc_r + 7'd1;
          end
        end
        ST_DIV: begin
          if (dcnt_r == 6'(DivSteps - 1)) begin
            pc_r <= pc_r + 7'd1;
          end
        end
        default: ;
      endcase

      // register write-back
      if (wb_en) begin
        case (wb_dst)
          D_I0: integ_r[0] <= wb_val;
          D_I1: integ_r[1] <= wb_val;
          D_I2: integ_r[2] <= wb_val;
          D_Q0: att_r[0]   <= wb_val;
          D_Q1: att_r[1]   <= wb_val;
          D_Q2: att_r[2]   <= wb_val;
          D_Q3: att_r[3]   <= wb_val;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      g_r[0] <= in_tdata[31:0];
      g_r[1] <= in_tdata[63:32];
      g_r[2] <= in_tdata[95:64];
      a_r[0] <= in_tdata[127:96];
      a_r[1] <= in_tdata[159:128];
      a_r[2] <= in_tdata[191:160];
      dt_r   <= in_tdata[215:192];
    end

    // multiplier stage, then accumulate
    if (state_r == ST_FETCH) begin
      prod_r <= mul_res;
    end
    if (state_r == ST_ACC) begin
      acc_r <= acc_nxt;
    end

    // square root: start and step
    if (state_r == ST_FETCH && uop.kind == K_SQRT) begin
      sqx_r   <= acc_r[63:0];
      sqr_r   <= '0;
      sqb_r   <= 64'h4000_0000_0000_0000;
      sqcnt_r <= '0;
    end else if (state_r == ST_SQRT) begin
      if (sq_ge) begin
        sqx_r <= sqx_r - sq_try;
        sqr_r <= (sqr_r >> 1) + sqb_r;
      end else begin
        sqr_r <= sqr_r >> 1;
      end
      sqb_r   <= sqb_r >> 2;
      sqcnt_r <= sqcnt_r + 5'd1;
      if (sqcnt_r == 5'(SqrtSteps - 1)) begin
        norm_r <= sq_ge ? (32'(sqr_r >> 1) + sqb_r[31:0]) : 32'(sqr_r >> 1);
      end
    end

    // divider: start and step
    if (state_r == ST_FETCH && uop.kind == K_DIV) begin
      dnum_r <= {dmag, 30'd0} + DivSteps'(norm_r >> 1);
      dneg_r <= op_a[32];
      drem_r <= '0;
      dquo_r <= '0;
      dcnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      dnum_r <= dnum_r << 1;
      drem_r <= d_ge ? 32'(d_try - {1'b0, norm_r}) : d_try[31:0];
      dquo_r <= d_quo;
      dcnt_r <= dcnt_r + 6'd1;
    end

    // working register write-back
    if (wb_en) begin
      case (wb_dst)
        D_V0:  v_r[0]  <= wb_val;
        D_V1:  v_r[1]  <= wb_val;
        D_V2:  v_r[2]  <= wb_val;
        D_E0:  e_r[0]  <= wb_val;
        D_E1:  e_r[1]  <= wb_val;
        D_E2:  e_r[2]  <= wb_val;
        D_G0:  g_r[0]  <= wb_val;
        D_G1:  g_r[1]  <= wb_val;
        D_G2:  g_r[2]  <= wb_val;
        D_H0:  h_r[0]  <= wb_val;
        D_H1:  h_r[1]  <= wb_val;
        D_H2:  h_r[2]  <= wb_val;
        D_QN0: qn_r[0] <= wb_val;
        D_QN1: qn_r[1] <= wb_val;
        D_QN2: qn_r[2] <= wb_val;
        D_QN3: qn_r[3] <= wb_val;
        D_AN0: an_r[0] <= wb_val;
        D_AN1: an_r[1] <= wb_val;
        D_AN2: an_r[2] <= wb_val;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {att_r[3], att_r[2], att_r[1], att_r[0]};
      out_user_r <= status_r;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  // a taken transfer closes the input until the result is formed
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken while busy");

  // a reset command restores the unit quaternion
  a_reset_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser) |=> (att_r[0] == OneQ30 && att_r[1] == '0))
    else $error("reset command did not restore attitude");

  // a result only appears from the completion state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside completion");

endmodule

>>> dv/aqf_checker.sv
`timescale 1ns / 100ps

module aqf_checker
  import aqf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [InDW-1:0]   in_tdata,
  input  logic              in_tuser,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [OutDW-1:0]  out_tdata,
  input  logic [1:0]        out_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_we,
  input  logic [CfgAW-1:0]  cfg_addr,
  input  logic [CfgW-1:0]   cfg_wdata,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                status_seen [4]
);

  typedef struct {
    logic signed [31:0] quat [4];
    status_t            status;
  } attitude_out_t;

  attitude_out_t pending_attitudes [$];

  // own copy of the gains, gate and filter state
  logic [30:0]        kp, ki, ilim, glow, ghigh;
  logic signed [31:0] att [4];
  logic signed [31:0] ierr [3];

  function automatic logic [63:0] absval(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  // exact product, shifted with rounding half away from zero
  function automatic longint rmul(longint a, longint b, int sh);
    logic [63:0] p;
    p = absval(a) * absval(b);
    p = (p + (64'd1 << (sh - 1))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint rdiv30(longint x, logic [63:0] d);
    logic [63:0] q;
    q = ((absval(x) << 30) + d / 2) / d;
    return clip32(x < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic clear_attitude();
    att[0] = OneQ30;
    att[1] = 0;
    att[2] = 0;
    att[3] = 0;
  endtask

  // one filter step on the local state
  task automatic fuse_sample(input logic [InDW-1:0] d, input logic rst_cmd,
                             output attitude_out_t r);
    longint g [3], a [3], q [4], qn [4], h [3], an [3], v [3], e [3], s;
    logic [63:0] ss, nm, nsq;
    if (rst_cmd) begin
      clear_attitude();
      for (int i = 0; i < 3; i++) ierr[i] = 0;
      r.status = STAT_RESET;
    end else begin
      for (int i = 0; i < 3; i++) begin
        g[i] = longint'($signed(d[32*i +: 32]));
        a[i] = longint'($signed(d[96 + 32*i +: 32]));
      end
      if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
        r.status = STAT_SKIP;
      end else begin
        ss = absval(a[0]) * absval(a[0]) + absval(a[1]) * absval(a[1])
           + absval(a[2]) * absval(a[2]);
        nm = root64(ss);
        for (int i = 0; i < 4; i++) q[i] = att[i];
        for (int i = 0; i < 3; i++) an[i] = rdiv30(a[i], nm);
        v[0] = clip32(2 * (rmul(q[1], q[3], 30) - rmul(q[0], q[2], 30)));
        v[1] = clip32(2 * (rmul(q[0], q[1], 30) + rmul(q[2], q[3], 30)));
        v[2] = clip32(rmul(q[0], q[0], 30) - rmul(q[1], q[1], 30)
                    - rmul(q[2], q[2], 30) + rmul(q[3], q[3], 30));
        if (nm > glow && nm < ghigh) begin
          e[0] = clip32(rmul(an[1], v[2], 30) - rmul(an[2], v[1], 30));
          e[1] = clip32(rmul(an[2], v[0], 30) - rmul(an[0], v[2], 30));
          e[2] = clip32(rmul(an[0], v[1], 30) - rmul(an[1], v[0], 30));
          for (int i = 0; i < 3; i++) begin
            s = longint'(ierr[i]) + rmul(e[i], longint'(ki), 24);
            if (s > longint'(ilim)) s = longint'(ilim);
            if (s < -longint'(ilim)) s = -longint'(ilim);
            ierr[i] = s[31:0];
            g[i] = clip32(g[i] + rmul(longint'(kp), e[i], 38)
                          + rmul(longint'(ierr[i]), 1, 14));
          end
          r.status = STAT_CORR;
        end else begin
          r.status = STAT_GYRO;
        end
        for (int i = 0; i < 3; i++) h[i] = clip32(rmul(g[i], longint'(d[215:192]), 11));
        qn[0] = q[0] - rmul(q[1], h[0], 30) - rmul(q[2], h[1], 30) - rmul(q[3], h[2], 30);
        qn[1] = q[1] + rmul(q[0], h[0], 30) + rmul(q[2], h[2], 30) - rmul(q[3], h[1], 30);
        qn[2] = q[2] + rmul(q[0], h[1], 30) - rmul(q[1], h[2], 30) + rmul(q[3], h[0], 30);
        qn[3] = q[3] + rmul(q[0], h[2], 30) + rmul(q[1], h[1], 30) - rmul(q[2], h[0], 30);
        nsq = 0;
        for (int i = 0; i < 4; i++) begin
          // symmetric saturation before renormalisation
          if (qn[i] > 64'sh7FFF_FFFF) qn[i] = 64'sh7FFF_FFFF;
          if (qn[i] < -64'sh7FFF_FFFF) qn[i] = -64'sh7FFF_FFFF;
          nsq = nsq + absval(qn[i]) * absval(qn[i]);
        end
        nm = root64(nsq);
        if (nm == 0) begin
          clear_attitude();
        end else begin
          for (int i = 0; i < 4; i++) att[i] = 32'(rdiv30(qn[i], nm));
        end
      end
    end
    for (int i = 0; i < 4; i++) r.quat[i] = att[i];
  endtask

  assign pending = pending_attitudes.size();

  always @(posedge clk) begin
    attitude_out_t want, got;
    if (!rst_n) begin
      kp    <= 31'd33554432;
      ki    <= 31'd83886;
      ilim  <= 31'd107374182;
      glow  <= 31'd52429;
      ghigh <= 31'd78643;
      clear_attitude();
      for (int i = 0; i < 3; i++) ierr[i] = 0;
      pending_attitudes.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_PROP_GAIN:      kp    <= cfg_wdata;
          REG_INTEGRAL_GAIN:  ki    <= cfg_wdata;
          REG_INTEGRAL_LIMIT: ilim  <= cfg_wdata;
          REG_GATE_LOW:       glow  <= cfg_wdata;
          REG_GATE_HIGH:      ghigh <= cfg_wdata;
          default: ;
        endcase
      end
      // input transfer: predict
      if (in_tvalid && in_tready) begin
        fuse_sample(in_tdata, in_tuser, want);
        pending_attitudes.push_back(want);
      end
      // result transfer: compare with oldest prediction
      if (out_tvalid && out_tready) begin
        for (int i = 0; i < 4; i++) got.quat[i] = out_tdata[32*i +: 32];
        got.status = status_t'(out_tuser);
        checked <= checked + 1;
        status_seen[out_tuser] <= status_seen[out_tuser] + 1;
        if (pending_attitudes.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("unexpected result transfer: quat %h status %0d", out_tdata, out_tuser);
        end else begin
          want = pending_attitudes.pop_front();
          if (want.quat != got.quat || want.status != got.status) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch at result %0d: exp w/x/y/z %h %h %h %h st %0d, got %h %h %h %h st %0d",
                       checked, want.quat[0], want.quat[1], want.quat[2], want.quat[3],
                       want.status, got.quat[0], got.quat[1], got.quat[2], got.quat[3],
                       got.status);
          end
        end
      end
    end
  end

  initial begin
    errors  = 0;
    checked = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import aqf_pkg::*;

  localparam int StallLimit = 20000;

  logic              clk;
  logic              rst_n;
  logic [InDW-1:0]   in_tdata;
  logic              in_tuser;
  logic              in_tvalid;
  logic              in_tready;
  logic [OutDW-1:0]  out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_we;
  logic [CfgAW-1:0]  cfg_addr;
  logic [CfgW-1:0]   cfg_wdata;

  int errors, pending, checked;
  int status_seen [4];
  int tx_idle_pct, rx_idle_pct;
  int samples_sent, idle_cycles;

  attitude_quaternion_fusion_top uut (.*);

  aqf_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("[attitude_quaternion_fusion_top] ERROR");
        $finish;
      end
    end
  end

  // one input transfer, with random sender gaps before it
  task automatic send(input logic mode, input logic [31:0] gx, gy, gz, ax, ay, az,
                      input logic [23:0] dt);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {dt, az, ay, ax, gz, gy, gx};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // drain, then rewrite every register
  task automatic set_regs(input logic [30:0] kp, ki, lim, lo, hi);
    logic [30:0] vals [5];
    vals = '{kp, ki, lim, lo, hi};
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CfgAW'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // random sample: mostly plausible motion, some resets, zero accel and noise
  task automatic random_item();
    int kind;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 24'($urandom));
    end else if (kind < 13) begin
      send(1'b0, $urandom, $urandom, $urandom, 0, 0, 0, 24'($urandom));
    end else if (kind < 75) begin
      send(1'b0, 32'($signed($urandom_range(262144)) - 131072),
           32'($signed($urandom_range(262144)) - 131072),
           32'($signed($urandom_range(262144)) - 131072),
           32'($signed($urandom_range(40000)) - 20000),
           32'($signed($urandom_range(40000)) - 20000),
           32'($signed($urandom_range(30000)) + 50000),
           24'($urandom_range(40000)));
    end else if (kind < 85) begin
      send(1'b0, 32'($signed($urandom_range(2000000)) - 1000000),
           32'($signed($urandom_range(2000000)) - 1000000),
           32'($signed($urandom_range(2000000)) - 1000000),
           32'($signed($urandom_range(300000)) - 150000),
           32'($signed($urandom_range(300000)) - 150000),
           32'($signed($urandom_range(300000)) - 150000),
           24'($urandom));
    end else begin
      send(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 24'($urandom));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tuser     = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    samples_sent = 0;
    idle_cycles  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset-value gains first
    send(1'b0, 32'd6554, -32'sd3277, 32'd1000, 0, 0, 0, 24'd16777);
    send(1'b0, 32'd6554, -32'sd3277, 32'd1000, 32'd3000, -32'sd2000, 32'd65536, 24'd16777);
    send(1'b0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 24'd16777);
    send(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd200000, 24'd16777);
    send(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
    send(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0, 32'd0, 24'd0);
    send(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send(1'b0, 32'h4000_0000, -32'sh4000_0000, 32'h2000_0000,
         -32'sd1, 32'd0, 32'd65536, 24'h80_0000);
    send(1'b0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, -32'sd65536, 24'hFF_FFFF);
    send(1'b0, 32'd1000, 32'd1000, 32'd1000, 32'd0, 32'd0, 32'd65536, 24'd16777);
    send(1'b1, 0, 0, 0, 0, 0, 0, 0);

    // strong gains, tight clamp: integral limit in use
    set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1000, 31'd0, 31'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) random_item();

    // phase 1: sender idles little, receiver idles a lot
    set_regs(31'd33554432, 31'd83886, 31'd107374182, 31'd52429, 31'd78643);
    tx_idle_pct = 23;
    rx_idle_pct = 79;
    for (int i = 0; i < 280; i++) begin
      random_item();
      // occasional full drain before the next sample
      if (i % 97 == 50) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    // phase 2: extremes, zero gains and wide-open gate, then full gains and a narrower gate
    set_regs(31'd0, 31'd0, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF);
    tx_idle_pct = 79;
    rx_idle_pct = 23;
    for (int i = 0; i < 140; i++) random_item();
    set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd30000, 31'd100000);
    for (int i = 0; i < 140; i++) random_item();

    // phase 3: no idling, gate closed, then moderate gains
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_regs(31'd16777216, 31'd1677722, 31'd0, 31'h7FFF_FFFF, 31'd0);
    for (int i = 0; i < 100; i++) random_item();
    set_regs(31'd8388608, 31'd167772, 31'd53687091, 31'd45000, 31'd90000);
    for (int i = 0; i < 170; i++) random_item();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);

    $display("sent %0d samples across six register settings; %0d results checked",
             samples_sent, checked);
    $display("status mix: corrected %0d, gyro-only %0d, skipped %0d, reset %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && pending == 0) begin
      $display("[attitude_quaternion_fusion_top] OK");
    end else begin
      $display("[attitude_quaternion_fusion_top] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/aqf_pkg.sv
rtl/core/attitude_quaternion_fusion_top.sv
dv/aqf_checker.sv
dv/testbench.sv
